@@ sv/sellp_sparse_matvec_assert.svh @@
// Assertion macros for the SELL-P sparse matrix-vector block.
// Included by sellp_sparse_matvec.sv; define ASSERT_OFF to compile them out.
`ifndef SELLP_SPARSE_MATVEC_ASSERT_SVH
`define SELLP_SPARSE_MATVEC_ASSERT_SVH
`ifndef ASSERT_OFF
`define SMV_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("SELL-P matvec assertion failed");
`define SMV_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("SELL-P matvec assertion failed");
`else
`define SMV_ASSERT(name, clk, rst, prop)
`define SMV_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ sv/smv_pkg.sv @@
// Package for the SELL-P sparse matrix-vector block: sizes, codes and the
// saturating accumulate. Depends on nothing.
`timescale 1ns / 1ps
package smv_pkg;

   localparam int LANES        = 4;
   localparam int COL_W        = 10;
   localparam int VECTOR_DEPTH = 1 << COL_W;
   localparam int DATA_W       = 32;
   localparam int ACC_W        = 64;
   localparam int ROW_W        = 16;
   localparam int SLICE_W      = 14;
   localparam int CNT_W        = $clog2(LANES + 1);

   typedef enum logic {
      KIND_VECTOR = 1'b0,
      KIND_CHUNK  = 1'b1
   } kind_type;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Signed add that clamps to the accumulator range instead of wrapping.
   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      logic signed [ACC_W:0] s;
      acc_type               r;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ sv/sellp_sparse_matvec.sv @@
// SELL-P sparse matrix times dense vector, Q16.16 inputs, Q32.32 saturated sums.
// Depends on smv_pkg and the assertion header sellp_sparse_matvec_assert.svh.
`timescale 1ns / 1ps
`include "sellp_sparse_matvec_assert.svh"

// The block accepts one word per clock on the request channel unless stalled:
// either a write into the dense vector store (kind 0) or one padded column
// chunk of the current slice (kind 1), carrying a matrix value and a column
// index for each of the four lanes. The vector store is held as four identical
// 1024 x 32 copies, one per lane, all written together, so that every lane
// reads its own column in the same cycle; entries never written read as
// undefined data. A chunk passes through three registered steps: the vector
// read at acceptance, the 32 x 32 lane multiplies, and the saturating add into
// the lane accumulators. When a chunk marked as the slice end reaches the
// accumulators, the four row sums move into a drain bank, the accumulators
// clear and the slice counter advances; the drain bank then gives one result
// word per cycle on the response channel unless rsp_stall is high, row numbers
// slice * 4 + lane, with last set on the fourth. A chunk is therefore accepted
// every cycle while unstalled, and the first row of a slice appears once its
// end chunk has passed the read and multiply registers and loaded the drain
// bank. The one source of request stall is the drain bank: a slice end that
// reaches the accumulators while the previous slice's rows are still waiting
// holds the whole pipeline until the bank is empty, so short slices wait on it
// and on any response stall. No clearing pass follows reset.
module sellp_sparse_matvec (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [smv_pkg::COL_W-1:0]       req_x_index,
   input  logic signed [smv_pkg::DATA_W-1:0] req_x_value,
   input  logic signed [smv_pkg::DATA_W-1:0] req_val0,
   input  logic signed [smv_pkg::DATA_W-1:0] req_val1,
   input  logic signed [smv_pkg::DATA_W-1:0] req_val2,
   input  logic signed [smv_pkg::DATA_W-1:0] req_val3,
   input  logic [smv_pkg::COL_W-1:0]       req_col0,
   input  logic [smv_pkg::COL_W-1:0]       req_col1,
   input  logic [smv_pkg::COL_W-1:0]       req_col2,
   input  logic [smv_pkg::COL_W-1:0]       req_col3,
   input  logic                            req_slice_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [smv_pkg::ROW_W-1:0]       rsp_row_index,
   output logic signed [smv_pkg::ACC_W-1:0] rsp_y_value,
   output logic                            rsp_last
);
   import smv_pkg::*;

   // Request fields gathered into lane arrays.
   data_type         req_val [LANES];
   logic [COL_W-1:0] req_col [LANES];

   logic accept;
   logic advance;
   logic pop;
   logic load;

   // Read stage: vector entries read at acceptance, matrix values alongside.
   logic     a_valid_ff, a_valid_in;
   logic     a_end_ff;
   data_type a_val_ff [LANES];
   data_type a_x      [LANES];

   // Multiply stage.
   logic     b_valid_ff, b_valid_in;
   logic     b_end_ff;
   acc_type  b_prod_ff [LANES];
   acc_type  b_prod_in [LANES];

   // Accumulators, slice counter and drain bank.
   acc_type            acc_ff  [LANES];
   acc_type            acc_in  [LANES];
   acc_type            acc_sum [LANES];
   logic [SLICE_W-1:0] slice_ff, slice_in;
   acc_type            drain_ff [LANES];
   acc_type            drain_in [LANES];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               acc_zero;

   assign req_val[0] = req_val0;
   assign req_val[1] = req_val1;
   assign req_val[2] = req_val2;
   assign req_val[3] = req_val3;
   assign req_col[0] = req_col0;
   assign req_col[1] = req_col1;
   assign req_col[2] = req_col2;
   assign req_col[3] = req_col3;

   // The pipeline moves as one; it holds only when a slice end is ready to
   // leave the accumulators while the drain bank still has rows in it.
   assign advance   = !(b_valid_ff && b_end_ff && (cnt_ff != '0));
   assign req_stall = !advance;
   assign accept    = req_valid && !req_stall;
   assign load      = advance && b_valid_ff && b_end_ff;

   assign rsp_valid     = (cnt_ff != '0);
   assign rsp_y_value   = drain_ff[0];
   assign rsp_row_index = row_ff;
   assign rsp_last      = (cnt_ff == CNT_W'(1));
   assign pop           = rsp_valid && !rsp_stall;

   // One copy of the vector store per lane; every copy sees every write.
   for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
      data_type vec_mem [VECTOR_DEPTH];
      data_type x_rd_ff;

      always_ff @(posedge clock) begin
         if (accept && (req_kind == KIND_VECTOR)) begin
            vec_mem[req_x_index] <= req_x_value;
         end
         if (accept) begin
            x_rd_ff <= vec_mem[req_col[ln]];
         end
      end

      assign a_x[ln] = x_rd_ff;
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      if (advance) begin
         a_valid_in = accept && (req_kind == KIND_CHUNK);
         b_valid_in = a_valid_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         b_prod_in[i] = acc_type'(a_val_ff[i]) * acc_type'(a_x[i]);
         acc_sum[i]   = sat_add(acc_ff[i], b_prod_ff[i]);
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      slice_in = slice_ff;
      if (advance && b_valid_ff) begin
         if (b_end_ff) begin
            for (int i = 0; i < LANES; i++) begin
               acc_in[i] = '0;
            end
            slice_in = slice_ff + SLICE_W'(1);
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   // The drain bank shifts towards entry 0, which drives the response.
   always_comb begin
      drain_in = drain_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;
      if (load) begin
         drain_in = acc_sum;
         cnt_in   = CNT_W'(LANES);
         row_in   = ROW_W'(32'(slice_ff) * LANES);
      end else if (pop) begin
         for (int i = 0; i < LANES - 1; i++) begin
            drain_in[i] = drain_ff[i + 1];
         end
         drain_in[LANES-1] = '0;
         cnt_in = cnt_ff - CNT_W'(1);
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         cnt_ff     <= '0;
         slice_ff   <= '0;
         for (int i = 0; i < LANES; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         cnt_ff     <= cnt_in;
         slice_ff   <= slice_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_end_ff <= req_slice_end;
         a_val_ff <= req_val;
      end
      if (advance) begin
         b_end_ff  <= a_end_ff;
         b_prod_ff <= b_prod_in;
      end
      drain_ff <= drain_in;
      row_ff   <= row_in;
   end

   always_comb begin
      acc_zero = 1'b1;
      for (int i = 0; i < LANES; i++) begin
         if (acc_ff[i] != '0) begin
            acc_zero = 1'b0;
         end
      end
   end

   // A retiring slice end fills the drain bank and starts the next slice clean.
   `SMV_ASSERT_NEXT(a_load_fills, clock, reset, load,
      (cnt_ff == CNT_W'(LANES)) && acc_zero)
   `SMV_ASSERT_NEXT(a_slice_step, clock, reset, load,
      (slice_ff == $past(slice_ff) + SLICE_W'(1)))
   // Once the last row of a slice is taken the drain bank is empty.
   `SMV_ASSERT_NEXT(a_last_empties, clock, reset, pop && rsp_last, (cnt_ff == '0))
   // The pipeline only holds behind a waiting slice end.
   `SMV_ASSERT(a_stall_cause, clock, reset, req_stall |-> (b_valid_ff && rsp_valid))

endmodule
